/* design/mare_pkg.sv */
// Shared types and fixed widths for the mean absolute / RMS error block.
package mare_pkg;

  localparam int DATA_W = 16;            // input sample width
  localparam int SQ_TERM_W = 2 * DATA_W; // one squared difference
  localparam int ROOT_W = 16;            // root result width
  localparam int RAD_W = 2 * ROOT_W;     // root radicand width

  typedef enum logic [2:0] {
    ST_ACCUM,
    ST_DRAIN,
    ST_DIV_ABS,
    ST_DIV_SQ,
    ST_ROOT_LD,
    ST_ROOT,
    ST_HOLD
  } mare_state_t;

  typedef struct packed {
    logic acc;        // accept one pair into the accumulators
    logic div_ld_abs; // load divider with the absolute sum
    logic div_ld_sq;  // load divider with the square sum
    logic div_step;   // one quotient bit
    logic mae_cap;    // capture mean absolute error from quotient
    logic root_ld;    // load root unit from quotient
    logic root_step;  // one root bit
    logic out_ld;     // load result registers and clear the run
  } mare_cmd_t;

endpackage

/* design/mare_ctrl.sv */
// Controller: sequences accumulation, the shared divider and the root unit.
module mare_ctrl #(
  parameter int SQ_W = 45
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_last_item,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output mare_pkg::mare_cmd_t cmd
);
  import mare_pkg::*;

  localparam int STEP_W = $clog2(SQ_W);

  mare_state_t      state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ACCUM;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    cmd           = '0;
    case (state_r)
      ST_ACCUM: begin
        in_ready = 1'b1;
        cmd.acc  = in_valid;
        if (in_valid && in_last_item) begin
          state_nxt = ST_DRAIN;
          step_nxt  = '0;
        end
      end
      ST_DRAIN: begin
        // wait for the square and add stages to settle
        if (step_r == STEP_W'(1)) begin
          cmd.div_ld_abs = 1'b1;
          state_nxt      = ST_DIV_ABS;
          step_nxt       = '0;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_DIV_ABS: begin
        cmd.div_step = 1'b1;
        if (step_r == STEP_W'(SQ_W - 1)) begin
          state_nxt = ST_DIV_SQ;
          step_nxt  = '0;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_DIV_SQ: begin
        // on entry: capture the abs quotient and reload the divider
        if (step_r == '0 && !cmd.div_step) begin
          cmd.mae_cap   = 1'b1;
          cmd.div_ld_sq = 1'b1;
          step_nxt      = STEP_W'(1);
        end else begin
          cmd.div_step = 1'b1;
          if (step_r == STEP_W'(SQ_W)) begin
            state_nxt = ST_ROOT_LD;
            step_nxt  = '0;
          end else begin
            step_nxt = step_r + 1'b1;
          end
        end
      end
      ST_ROOT_LD: begin
        cmd.root_ld = 1'b1;
        state_nxt   = ST_ROOT;
        step_nxt    = '0;
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        if (step_r == STEP_W'(ROOT_W - 1)) begin
          state_nxt = ST_HOLD;
          step_nxt  = '0;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_HOLD: begin
        // hold until the previous result has been taken
        if (!out_valid_r || out_ready) begin
          cmd.out_ld    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_ACCUM;
        end
      end
      default: begin
        state_nxt = ST_ACCUM;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

/* design/mare_dp.sv */
// Datapath: accumulators, shared restoring divider, digit-by-digit root.
module mare_dp #(
  parameter int MAX_ITEMS = 4096,
  parameter int CNT_W = 13,
  parameter int SQ_W = 45
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  mare_pkg::mare_cmd_t          cmd,
  input  logic [mare_pkg::DATA_W-1:0]  in_predicted_value,
  input  logic [mare_pkg::DATA_W-1:0]  in_actual_value,
  output logic [mare_pkg::DATA_W-1:0]  out_mean_abs_error,
  output logic [mare_pkg::ROOT_W-1:0]  out_rms_error,
  output logic [CNT_W-1:0]             out_pair_count,
  output logic                         out_count_overflow
);
  import mare_pkg::*;

  localparam int ABS_W = DATA_W + CNT_W;

  // accumulation
  logic [CNT_W-1:0]     count_r;
  logic                 ovf_r;
  logic                 va_r, vb_r;
  logic [DATA_W-1:0]    ad_r;
  logic [SQ_TERM_W-1:0] sq_r;
  logic [ABS_W-1:0]     abs_sum_r;
  logic [SQ_W-1:0]      sq_sum_r;
  logic signed [DATA_W:0] diff;
  logic [DATA_W-1:0]    ad;
  logic                 room;

  // divider and root
  logic [SQ_W-1:0]    quo_r, quo_nxt;
  logic [CNT_W-1:0]   rem_r, rem_nxt;
  logic [CNT_W:0]     div_sh;
  logic [RAD_W-1:0]   rad_r;
  logic [ROOT_W+1:0]  rrem_r, rrem_nxt;
  logic [ROOT_W-1:0]  root_r, root_nxt;
  logic [ROOT_W+3:0]  root_sh, root_trial;
  logic [DATA_W-1:0]  mae_r;

  // result registers
  logic [DATA_W-1:0]  out_mae_r;
  logic [ROOT_W-1:0]  out_rms_r;
  logic [CNT_W-1:0]   out_cnt_r;
  logic               out_ovf_r;

  assign diff = {in_predicted_value[DATA_W-1], in_predicted_value}
              - {in_actual_value[DATA_W-1], in_actual_value};
  assign ad   = diff[DATA_W] ? DATA_W'(-diff) : diff[DATA_W-1:0];
  assign room = (CNT_W + 1)'(count_r) < (CNT_W + 1)'(MAX_ITEMS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      ovf_r     <= 1'b0;
      va_r      <= 1'b0;
      vb_r      <= 1'b0;
      abs_sum_r <= '0;
      sq_sum_r  <= '0;
    end else if (cmd.out_ld) begin
      count_r   <= '0;
      ovf_r     <= 1'b0;
      va_r      <= 1'b0;
      vb_r      <= 1'b0;
      abs_sum_r <= '0;
      sq_sum_r  <= '0;
    end else begin
      va_r <= cmd.acc && room;
      vb_r <= va_r;
      if (cmd.acc) begin
        if (room) begin
          count_r <= count_r + 1'b1;
        end else begin
          ovf_r <= 1'b1;
        end
      end
      if (va_r) begin
        abs_sum_r <= abs_sum_r + ABS_W'(ad_r);
      end
      if (vb_r) begin
        sq_sum_r <= sq_sum_r + SQ_W'(sq_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    ad_r <= ad;
    sq_r <= SQ_TERM_W'(ad_r) * SQ_TERM_W'(ad_r);
  end

  // restoring divide by the pair count, one quotient bit a cycle
  always_comb begin
    div_sh  = {rem_r, quo_r[SQ_W-1]};
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    if (cmd.div_ld_abs) begin
      rem_nxt = '0;
      quo_nxt = SQ_W'(abs_sum_r);
    end else if (cmd.div_ld_sq) begin
      rem_nxt = '0;
      quo_nxt = sq_sum_r;
    end else if (cmd.div_step) begin
      if (div_sh >= {1'b0, count_r}) begin
        rem_nxt = CNT_W'(div_sh - {1'b0, count_r});
        quo_nxt = {quo_r[SQ_W-2:0], 1'b1};
      end else begin
        rem_nxt = div_sh[CNT_W-1:0];
        quo_nxt = {quo_r[SQ_W-2:0], 1'b0};
      end
    end
  end

  // integer square root, two radicand bits a cycle
  always_comb begin
    root_sh    = {rrem_r, rad_r[RAD_W-1 -: 2]};
    root_trial = (ROOT_W + 4)'({root_r, 2'b01});
    rrem_nxt   = rrem_r;
    root_nxt   = root_r;
    if (root_sh >= root_trial) begin
      rrem_nxt = (ROOT_W + 2)'(root_sh - root_trial);
      root_nxt = {root_r[ROOT_W-2:0], 1'b1};
    end else begin
      rrem_nxt = root_sh[ROOT_W+1:0];
      root_nxt = {root_r[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (cmd.mae_cap) begin
      mae_r <= quo_r[DATA_W-1:0];
    end
    if (cmd.root_ld) begin
      rad_r  <= quo_r[RAD_W-1:0];
      rrem_r <= '0;
      root_r <= '0;
    end else if (cmd.root_step) begin
      rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
      rrem_r <= rrem_nxt;
      root_r <= root_nxt;
    end
    if (cmd.out_ld) begin
      out_mae_r <= mae_r;
      out_rms_r <= root_r;
      out_cnt_r <= count_r;
      out_ovf_r <= ovf_r;
    end
  end

  assign out_mean_abs_error = out_mae_r;
  assign out_rms_error      = out_rms_r;
  assign out_pair_count     = out_cnt_r;
  assign out_count_overflow = out_ovf_r;

endmodule

/* design/mean_abs_and_rms_error_core.sv */
// Top level: mean absolute error and RMS error over runs of value pairs.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_ready  in_predicted_value, in_actual_value, in_last_item
//   out_     output     out_valid/out_ready  out_mean_abs_error, out_rms_error,
//                                            out_pair_count, out_count_overflow
//
// Pairs of a run are taken one per cycle. After the last pair the input stalls while
// the square/add pipe drains, the shared bit-serial divider makes two passes, the
// first quotient is captured, the root unit is loaded and stepped through its bits,
// and the result is published.
// The result waits in an output register while the next run is taken; that run's last
// request holds in the final state until the previous result has been taken.
// rst_n is synchronous and clears the sums, the count and out_valid, and returns the controller to accumulation.
module mean_abs_and_rms_error_core #(
  parameter int MAX_ITEMS = 4096
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [mare_pkg::DATA_W-1:0]        in_predicted_value,
  input  logic [mare_pkg::DATA_W-1:0]        in_actual_value,
  input  logic                               in_last_item,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [mare_pkg::DATA_W-1:0]        out_mean_abs_error,
  output logic [mare_pkg::ROOT_W-1:0]        out_rms_error,
  output logic [$clog2(MAX_ITEMS + 1)-1:0]   out_pair_count,
  output logic                               out_count_overflow
);
  import mare_pkg::*;

  // pair count: wide enough to hold MAX_ITEMS itself
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  // square sum: one 32-bit term per counted pair
  localparam int SQ_W = SQ_TERM_W + CNT_W;

  mare_cmd_t cmd;

  // sequence the run: accumulate, drain, divide twice, take the root, publish
  mare_ctrl #(
    .SQ_W(SQ_W)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_last_item(in_last_item),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .cmd         (cmd)
  );

  // accumulators, divider, root unit and result registers
  mare_dp #(
    .MAX_ITEMS(MAX_ITEMS),
    .CNT_W    (CNT_W),
    .SQ_W     (SQ_W)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_predicted_value(in_predicted_value),
    .in_actual_value   (in_actual_value),
    .out_mean_abs_error(out_mean_abs_error),
    .out_rms_error     (out_rms_error),
    .out_pair_count    (out_pair_count),
    .out_count_overflow(out_count_overflow)
  );

endmodule

/* verif/mean_abs_and_rms_error_core_tb.sv */
// Self-checking testbench for the mean absolute / RMS error core.
`timescale 1ns / 1ps

module mean_abs_and_rms_error_core_tb;

  import mare_pkg::*;

  localparam int MAX_ITEMS = 4096;
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int STALL_LIMIT = 3000;  // cycles with no request moving on either side
  localparam int SETTLE_CYCLES = 150; // covers the divide/root tail after the last pair
  localparam int RANDOM_PAIRS = 460;

  // Metrics of one finished run, as the block should report them.
  typedef struct {
    logic [DATA_W-1:0] mae;
    logic [ROOT_W-1:0] rms;
    logic [CNT_W-1:0]  count;
    logic              overflow;
  } run_metrics_t;

  // Keeps running sums of the current run and the metrics still owed by the block.
  class error_metric_tracker;
    longint unsigned abs_total;
    longint unsigned square_total;
    int unsigned     pair_total;
    bit              saturated;
    run_metrics_t    owed[$];
    int unsigned     mismatches;

    function void clear_run();
      abs_total = 0;
      square_total = 0;
      pair_total = 0;
      saturated = 0;
    endfunction

    function longint unsigned floor_root(longint unsigned x);
      longint unsigned res;
      longint unsigned bit_v;
      res = 0;
      bit_v = 64'd1 << 62;
      while (bit_v > x) bit_v >>= 2;
      while (bit_v != 0) begin
        if (x >= res + bit_v) begin
          x -= res + bit_v;
          res = (res >> 1) + bit_v;
        end else begin
          res >>= 1;
        end
        bit_v >>= 2;
      end
      return res;
    endfunction

    function void absorb_pair(logic [DATA_W-1:0] p, logic [DATA_W-1:0] a, logic is_last);
      int              diff;
      longint unsigned mag;
      run_metrics_t    m;
      if (pair_total < MAX_ITEMS) begin
        diff = $signed(p) - $signed(a);
        mag = (diff < 0) ? longint'(-diff) : longint'(diff);
        abs_total += mag;
        square_total += mag * mag;
        pair_total++;
      end else begin
        saturated = 1;
      end
      if (!is_last) return;
      m.mae = '0;
      m.rms = '0;
      if (pair_total != 0) begin
        m.mae = DATA_W'(abs_total / pair_total);
        m.rms = ROOT_W'(floor_root(square_total / pair_total));
      end
      m.count = CNT_W'(pair_total);
      m.overflow = saturated;
      owed = {owed, m};
      clear_run();
    endfunction

    function void check_metrics(logic [DATA_W-1:0] mae, logic [ROOT_W-1:0] rms,
                                logic [CNT_W-1:0] count, logic overflow);
      run_metrics_t want;
      if (owed.size() == 0) begin
        $error("result with none outstanding: mae %0d rms %0d count %0d overflow %0d",
               mae, rms, count, overflow);
        mismatches++;
        return;
      end
      want = owed.pop_front();
      if (mae !== want.mae) begin
        $error("mean_abs_error: expected %0d, actual %0d", want.mae, mae);
        mismatches++;
      end
      if (rms !== want.rms) begin
        $error("rms_error: expected %0d, actual %0d", want.rms, rms);
        mismatches++;
      end
      if (count !== want.count) begin
        $error("pair_count: expected %0d, actual %0d", want.count, count);
        mismatches++;
      end
      if (overflow !== want.overflow) begin
        $error("count_overflow: expected %0d, actual %0d", want.overflow, overflow);
        mismatches++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [DATA_W-1:0] in_predicted_value;
  logic [DATA_W-1:0] in_actual_value;
  logic              in_last_item;
  logic              out_valid;
  logic              out_ready;
  logic [DATA_W-1:0] out_mean_abs_error;
  logic [ROOT_W-1:0] out_rms_error;
  logic [CNT_W-1:0]  out_pair_count;
  logic              out_count_overflow;

  error_metric_tracker tracker;
  bit          steady;        // no random idling on either side while set
  int          hold_off_left; // cycles the receiver still refuses results
  int          quiet_cycles;
  int unsigned pairs_sent;

  mean_abs_and_rms_error_core #(
    .MAX_ITEMS(MAX_ITEMS)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_predicted_value(in_predicted_value),
    .in_actual_value(in_actual_value),
    .in_last_item(in_last_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_mean_abs_error(out_mean_abs_error),
    .out_rms_error(out_rms_error),
    .out_pair_count(out_pair_count),
    .out_count_overflow(out_count_overflow)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: drop ready for a counted hold-off when asked, else idle at random.
  always @(negedge clk) begin
    if (hold_off_left > 0) begin
      out_ready = 1'b0;
      hold_off_left--;
    end else begin
      out_ready = steady || ($urandom_range(99) >= 6);
    end
  end

  // Check every result request against the oldest owed metrics.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      tracker.check_metrics(out_mean_abs_error, out_rms_error, out_pair_count,
                            out_count_overflow);
  end

  // Watchdog: end the run if no request moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Offer one pair from a falling edge and hold it until the block takes it.
  task automatic send_pair(input logic [DATA_W-1:0] p, input logic [DATA_W-1:0] a,
                           input logic is_last);
    @(negedge clk);
    if (!steady) begin
      while ($urandom_range(99) < 6) begin
        in_valid = 1'b0;
        @(negedge clk);
      end
    end
    in_valid = 1'b1;
    in_predicted_value = p;
    in_actual_value = a;
    in_last_item = is_last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.absorb_pair(p, a, is_last);
    pairs_sent++;
  endtask

  // Lower valid, then wait until the block has delivered everything owed.
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (tracker.owed.size() != 0) @(posedge clk);
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(3))
      0: begin
        case ($urandom_range(3))
          0: return 16'h7FFF;
          1: return 16'h8000;
          2: return 16'h0000;
          default: return 16'hFFFF;
        endcase
      end
      default: return DATA_W'($urandom());
    endcase
  endfunction

  // Send one run; full_swing keeps every difference at its largest magnitude.
  task automatic send_run(input int len, input bit full_swing);
    logic [DATA_W-1:0] p;
    logic [DATA_W-1:0] a;
    for (int i = 0; i < len; i++) begin
      if (full_swing) begin
        p = (i % 2) ? 16'h8000 : 16'h7FFF;
        a = (i % 2) ? 16'h7FFF : 16'h8000;
      end else begin
        p = pick_value();
        // keep about half the pairs close together so small errors show up too
        a = ($urandom_range(1)) ? pick_value() : DATA_W'(p + $urandom_range(64) - 32);
      end
      send_pair(p, a, i == len - 1);
    end
  endtask

  initial begin
    int len;
    bit drained;
    tracker = new();
    tracker.clear_run();
    tracker.mismatches = 0;
    steady = 1'b0;
    drained = 1'b0;
    hold_off_left = 0;
    quiet_cycles = 0;
    pairs_sent = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_predicted_value = '0;
    in_actual_value = '0;
    in_last_item = 1'b0;
    out_ready = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: single-pair runs at both extremes of the difference and zero.
    send_pair(16'h7FFF, 16'h8000, 1'b1);
    send_pair(16'h8000, 16'h7FFF, 1'b1);
    send_pair(16'h0000, 16'h0000, 1'b1);
    // mixed signs, one pair with no error
    send_pair(16'hFFFF, 16'h0000, 1'b0);
    send_pair(16'h0000, 16'hFFFF, 1'b0);
    send_pair(16'h1234, 16'h1234, 1'b1);
    // equal extremes, then half-range differences
    send_pair(16'h7FFF, 16'h7FFF, 1'b0);
    send_pair(16'h8000, 16'h8000, 1'b0);
    send_pair(16'h8000, 16'h0000, 1'b0);
    send_pair(16'h0000, 16'h7FFF, 1'b1);
    // alternating bit patterns
    send_pair(16'h5555, 16'hAAAA, 1'b0);
    send_pair(16'hAAAA, 16'h5555, 1'b1);
    // small differences where the square-sum divide truncates
    send_pair(16'h0010, 16'h0000, 1'b0);
    send_pair(16'h0000, 16'h0011, 1'b0);
    send_pair(16'h0003, 16'h0000, 1'b1);

    // Hold the receiver off while short runs keep coming, so the output
    // register fills and the input stalls behind it.
    hold_off_left = 300;
    repeat (6) send_run($urandom_range(1, 3), 1'b0);

    // Random runs, mostly short, a few longer; pause once for a full drain.
    pairs_sent = 0;
    while (pairs_sent < RANDOM_PAIRS) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      send_run(len, 1'b0);
      if (!drained && pairs_sent >= RANDOM_PAIRS / 2) begin
        drain_results();
        drained = 1'b1;
      end
    end

    // Long stretch with no idling: a full-swing run, then a shorter random one.
    steady = 1'b1;
    send_run(64, 1'b1);
    send_run(40, 1'b0);
    steady = 1'b0;

    // A few short runs with idling back on, then wind down.
    repeat (5) send_run($urandom_range(1, 6), 1'b0);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (tracker.mismatches == 0 && tracker.owed.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/mare_pkg.sv
design/mare_ctrl.sv
design/mare_dp.sv
design/mean_abs_and_rms_error_core.sv
verif/mean_abs_and_rms_error_core_tb.sv
